// ===== hdl/block_transfer_address_sequencer_top_macros.svh =====
// Assertion macros for the block transfer address sequencer.
// Used by the RTL module btas_back to check its own control logic.
`ifndef BLOCK_TRANSFER_ADDRESS_SEQUENCER_TOP_MACROS_SVH
`define BLOCK_TRANSFER_ADDRESS_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btas: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BTAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btas: next-cycle check failed");

`endif

// ===== hdl/btas_pkg.sv =====
// Shared types and constants of the block transfer address sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btas_pkg;

    localparam int unsigned AddrW    = 32;
    localparam int unsigned NumRegs  = 16;
    localparam int unsigned RegIdxW  = 4;
    localparam int unsigned CntW     = 5;
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = 1;
    localparam int unsigned QCntW    = 2;

    localparam logic [AddrW-1:0] WordBytes = 32'd4;
    localparam logic [AddrW-1:0] PcAhead   = 32'd12;

    localparam logic FuncStore = 1'b0;
    localparam logic FuncLoad  = 1'b1;

    // One classified instruction, ready for the sequencer.
    typedef struct packed {
        logic               func;
        logic [NumRegs-1:0] mask;
        logic [AddrW-1:0]   lowest;
        logic [AddrW-1:0]   pc_value;
        logic [AddrW-1:0]   new_base;
        logic               base_we;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic               transfer_valid;
        logic [AddrW-1:0]   address;
        logic [RegIdxW-1:0] register_index;
        logic               is_load;
        logic [AddrW-1:0]   pc_store_value;
        logic [AddrW-1:0]   new_base_value;
        logic               base_write_enable;
        logic               last;
    } t_result;

    // Count set bits: nibble counts first, then a short sum.
    function automatic logic [CntW-1:0] popcount16(input logic [NumRegs-1:0] v);
        logic [2:0] nib [4];
        logic [CntW-1:0] sum;
        for (int i = 0; i < 4; i++) begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        sum = (CntW'(nib[0]) + CntW'(nib[1])) + (CntW'(nib[2]) + CntW'(nib[3]));
        return sum;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/btas_front.sv =====
// Front end: accepts an instruction and classifies it into a command.
// Depends on btas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btas_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [15:0]                 i_register_mask,
    input  wire logic [3:0]                  i_base_register,
    input  wire logic [31:0]                 i_base_value,
    input  wire logic                        i_pre_index,
    input  wire logic                        i_up,
    input  wire logic                        i_write_back,
    input  wire logic [31:0]                 i_instruction_address,
    output logic                             o_cmd_valid,
    output btas_pkg::t_cmd                   o_cmd,
    input  wire logic                        i_cmd_ready
);
    import btas_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic       accept;
    logic [CntW-1:0]  cnt;
    logic [AddrW-1:0] span;

    assign o_stall = r_valid & ~i_cmd_ready;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        cnt  = popcount16(i_register_mask);
        span = {{(AddrW-CntW-2){1'b0}}, cnt, 2'b00};
        n_cmd.func     = i_func;
        n_cmd.mask     = i_register_mask;
        n_cmd.pc_value = i_instruction_address + PcAhead;
        if (i_up) begin
            n_cmd.new_base = i_base_value + span;
            n_cmd.lowest   = i_pre_index ? i_base_value + WordBytes : i_base_value;
        end else begin
            n_cmd.new_base = i_base_value - span;
            n_cmd.lowest   = i_pre_index ? i_base_value - span
                                         : i_base_value - span + WordBytes;
        end
        // Drop writeback for a load that reloads the base.
        n_cmd.base_we = i_write_back
                      & ~((i_func == FuncLoad) & i_register_mask[i_base_register]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule
`default_nettype wire

// ===== hdl/btas_queue.sv =====
// Short command queue between front end and sequencer.
// Depends on btas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btas_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_valid,
    input  wire btas_pkg::t_cmd  i_wr_cmd,
    output logic                 o_wr_ready,
    output logic                 o_rd_valid,
    output btas_pkg::t_cmd       o_rd_cmd,
    input  wire logic            i_rd_pop
);
    import btas_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_wr_ready = (r_count != QCntW'(QDepth));
    assign o_rd_valid = (r_count != '0);
    assign wr = i_wr_valid & o_wr_ready;
    assign rd = i_rd_pop & o_rd_valid;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({wr, rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/btas_back.sv =====
// Back end: walks the register mask of one command, one transfer a cycle while not stalled.
// Depends on btas_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "block_transfer_address_sequencer_top_macros.svh"
module btas_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire btas_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    output btas_pkg::t_result    o_result,
    input  wire logic            i_stall
);
    import btas_pkg::*;

    logic               r_busy;
    t_cmd               r_cmd;
    logic [AddrW-1:0]   r_addr;
    logic               r_out_valid;
    t_result            r_out;
    logic               out_free;
    logic               step;
    logic [RegIdxW-1:0] idx;
    logic [NumRegs-1:0] remain;
    logic               fin;
    t_result            n_out;

    assign out_free = ~r_out_valid | ~i_stall;
    assign step     = r_busy & out_free;
    assign o_pop    = ~r_busy & i_cmd_valid;

    always_comb begin
        idx = '0;
        for (int i = NumRegs - 1; i >= 0; i--) begin
            if (r_cmd.mask[i]) idx = RegIdxW'(i);
        end
        remain = r_cmd.mask & (r_cmd.mask - 1'b1);
        fin    = (remain == '0);
        n_out.transfer_valid    = (r_cmd.mask != '0);
        n_out.address           = n_out.transfer_valid ? r_addr : '0;
        n_out.register_index    = idx;
        n_out.is_load           = r_cmd.func;
        n_out.pc_store_value    = r_cmd.pc_value;
        n_out.new_base_value    = fin ? r_cmd.new_base : '0;
        n_out.base_write_enable = fin ? r_cmd.base_we : 1'b0;
        n_out.last              = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (step && fin) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_addr <= i_cmd.lowest;
        end else if (step) begin
            r_cmd.mask <= remain;
            r_addr     <= r_addr + WordBytes;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `BTAS_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, r_out_valid && !r_out.transfer_valid, r_out.last)
    `BTAS_ASSERT_IMP(a_more_pending, i_clk, i_rst_n, r_out_valid && !r_out.last, r_busy)
    `BTAS_ASSERT_NXT(a_last_frees, i_clk, i_rst_n, step && fin, !r_busy || $past(o_pop))

endmodule
`default_nettype wire

// ===== hdl/block_transfer_address_sequencer_top.sv =====
// An instruction's first transfer passes the front register, the queue, the sequencer's
// command register and the output register; an empty mask still gives one marker result.
// Throughput: one transfer per cycle while the receiver does not stall; the sequencer
// takes a new instruction only after the last transfer of the one before it.
// Reset: synchronous, active low; clears the front, queue and sequencer control.
// Depends on btas_pkg, btas_front, btas_queue and btas_back.
`timescale 1ns / 1ps
`default_nettype none
module block_transfer_address_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel: one block load/store instruction per transfer
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [15:0] i_register_mask,
    input  wire logic [3:0]  i_base_register,
    input  wire logic [31:0] i_base_value,
    input  wire logic        i_pre_index,
    input  wire logic        i_up,
    input  wire logic        i_write_back,
    input  wire logic [31:0] i_instruction_address,
    // Output channel: one memory access per transfer, or a marker for an empty mask
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_transfer_valid,
    output logic [31:0]      o_address,
    output logic [3:0]       o_register_index,
    output logic             o_is_load,
    output logic [31:0]      o_pc_store_value,
    output logic [31:0]      o_new_base_value,
    output logic             o_base_write_enable,
    output logic             o_last
);
    import btas_pkg::*;

    // Front to queue
    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_wr_ready;
    // Queue to sequencer
    logic    q_rd_valid;
    t_cmd    q_rd_cmd;
    logic    back_pop;
    // Sequencer output register
    t_result result;

    // Classify the instruction: count, lowest address, new base, writeback.
    btas_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_func                (i_func),
        .i_register_mask       (i_register_mask),
        .i_base_register       (i_base_register),
        .i_base_value          (i_base_value),
        .i_pre_index           (i_pre_index),
        .i_up                  (i_up),
        .i_write_back          (i_write_back),
        .i_instruction_address (i_instruction_address),
        .o_cmd_valid           (front_valid),
        .o_cmd                 (front_cmd),
        .i_cmd_ready           (q_wr_ready)
    );

    // Hold classified commands so the front keeps accepting while the walk runs.
    btas_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_cmd   (front_cmd),
        .o_wr_ready (q_wr_ready),
        .o_rd_valid (q_rd_valid),
        .o_rd_cmd   (q_rd_cmd),
        .i_rd_pop   (back_pop)
    );

    // Walk the mask lowest register first, advancing the address by a word.
    btas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_rd_valid),
        .i_cmd       (q_rd_cmd),
        .o_pop       (back_pop),
        .o_valid     (o_valid),
        .o_result    (result),
        .i_stall     (i_stall)
    );

    assign o_transfer_valid    = result.transfer_valid;
    assign o_address           = result.address;
    assign o_register_index    = result.register_index;
    assign o_is_load           = result.is_load;
    assign o_pc_store_value    = result.pc_store_value;
    assign o_new_base_value    = result.new_base_value;
    assign o_base_write_enable = result.base_write_enable;
    assign o_last              = result.last;

endmodule
`default_nettype wire

// ===== dv/block_transfer_address_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_transfer_address_sequencer_top: block load/store
// instructions go in, and every memory transfer that comes out is checked against a
// local prediction. Depends on btas_pkg and the RTL of the sequencer.
module block_transfer_address_sequencer_top_tb;
    import btas_pkg::*;

    localparam int unsigned DrainLimit  = 20000;  // cycles allowed for the last transfers
    localparam int unsigned SettleTime  = 12;     // waited out after the drain so stray results can show up
    localparam int unsigned MaxPrinted  = 200;    // keep the log short on a broken build
    localparam int unsigned RandomItems = 150;
    localparam int unsigned LongHold    = 300;

    // One block load/store instruction as it sits on the input channel.
    typedef struct packed {
        logic               func;
        logic [NumRegs-1:0] mask;
        logic [3:0]         base_reg;
        logic [AddrW-1:0]   base;
        logic               pre;
        logic               up;
        logic               wb;
        logic [AddrW-1:0]   iaddr;
    } t_instr;

    // Predicts the transfers of each accepted instruction and checks them in order.
    class transfer_scoreboard;
        t_result     expected_transfers[$];
        int unsigned mismatch_count = 0;

        task report_mismatch(input string what);
            if (mismatch_count < MaxPrinted) begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
            mismatch_count++;
        endtask

        // Expand one instruction into its transfers, lowest register at lowest address.
        function void note_instruction(input t_instr ins);
            int unsigned      count;
            int unsigned      k;
            logic [AddrW-1:0] span;
            logic [AddrW-1:0] lowest;
            logic [AddrW-1:0] pc_val;
            logic [AddrW-1:0] new_base;
            logic             wr_en;
            t_result          r;
            count = 0;
            for (int i = 0; i < NumRegs; i++) begin
                count += ins.mask[i];
            end
            span     = count * WordBytes;
            pc_val   = ins.iaddr + PcAhead;
            new_base = ins.up ? ins.base + span : ins.base - span;
            // Drop the writeback when a load overwrites the base anyway.
            wr_en = ins.wb;
            if (ins.func == FuncLoad && ins.mask[ins.base_reg]) begin
                wr_en = 1'b0;
            end
            if (ins.up) begin
                lowest = ins.pre ? ins.base + WordBytes : ins.base;
            end else begin
                lowest = ins.pre ? ins.base - span : ins.base - span + WordBytes;
            end
            if (count == 0) begin
                // Empty mask: a single marker result, no real transfer.
                r = '0;
                r.is_load           = ins.func;
                r.pc_store_value    = pc_val;
                r.new_base_value    = new_base;
                r.base_write_enable = wr_en;
                r.last              = 1'b1;
                expected_transfers = {expected_transfers, r};
                return;
            end
            k = 0;
            for (int i = 0; i < NumRegs; i++) begin
                if (ins.mask[i]) begin
                    r = '0;
                    r.transfer_valid = 1'b1;
                    r.address        = lowest + k * WordBytes;
                    r.register_index = RegIdxW'(i);
                    r.is_load        = ins.func;
                    r.pc_store_value = pc_val;
                    if (k + 1 == count) begin
                        r.new_base_value    = new_base;
                        r.base_write_enable = wr_en;
                        r.last              = 1'b1;
                    end
                    expected_transfers = {expected_transfers, r};
                    k++;
                end
            end
        endfunction

        function void compare_field(input string name, input logic [31:0] got,
                                    input logic [31:0] want, inout string bad);
            if (got !== want) begin
                bad = {bad, $sformatf(" %s=%0h(exp %0h)", name, got, want)};
            end
        endfunction

        task check_transfer(input t_result got);
            t_result want;
            string   bad;
            if (expected_transfers.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer addr=%0h reg=%0d",
                                          got.address, got.register_index));
                return;
            end
            want = expected_transfers.pop_front();
            bad  = "";
            compare_field("transfer_valid", 32'(got.transfer_valid),
                          32'(want.transfer_valid), bad);
            compare_field("address", got.address, want.address, bad);
            compare_field("register_index", 32'(got.register_index),
                          32'(want.register_index), bad);
            compare_field("is_load", 32'(got.is_load), 32'(want.is_load), bad);
            compare_field("pc_store_value", got.pc_store_value, want.pc_store_value, bad);
            compare_field("new_base_value", got.new_base_value, want.new_base_value, bad);
            compare_field("base_write_enable", 32'(got.base_write_enable),
                          32'(want.base_write_enable), bad);
            compare_field("last", 32'(got.last), 32'(want.last), bad);
            if (bad != "") begin
                report_mismatch({"transfer:", bad});
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [15:0] i_register_mask;
    logic [3:0]  i_base_register;
    logic [31:0] i_base_value;
    logic        i_pre_index;
    logic        i_up;
    logic        i_write_back;
    logic [31:0] i_instruction_address;
    logic        o_valid;
    logic        i_stall;
    logic        o_transfer_valid;
    logic [31:0] o_address;
    logic [3:0]  o_register_index;
    logic        o_is_load;
    logic [31:0] o_pc_store_value;
    logic [31:0] o_new_base_value;
    logic        o_base_write_enable;
    logic        o_last;

    transfer_scoreboard sb = new();
    t_instr             stimulus[$];

    block_transfer_address_sequencer_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_func                (i_func),
        .i_register_mask       (i_register_mask),
        .i_base_register       (i_base_register),
        .i_base_value          (i_base_value),
        .i_pre_index           (i_pre_index),
        .i_up                  (i_up),
        .i_write_back          (i_write_back),
        .i_instruction_address (i_instruction_address),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_transfer_valid      (o_transfer_valid),
        .o_address             (o_address),
        .o_register_index      (o_register_index),
        .o_is_load             (o_is_load),
        .o_pc_store_value      (o_pc_store_value),
        .o_new_base_value      (o_new_base_value),
        .o_base_write_enable   (o_base_write_enable),
        .o_last                (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample both channels at the edge; a transfer counts when valid is high and stall low.
    always @(posedge i_clk) begin
        t_instr  ins;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                ins = '{i_func, i_register_mask, i_base_register, i_base_value,
                        i_pre_index, i_up, i_write_back, i_instruction_address};
                sb.note_instruction(ins);
            end
            if (o_valid && !i_stall) begin
                got = '{o_transfer_valid, o_address, o_register_index, o_is_load,
                        o_pc_store_value, o_new_base_value, o_base_write_enable, o_last};
                sb.check_transfer(got);
            end
        end
    end

    function automatic t_instr make_instr(input logic func, input logic [15:0] mask,
                                          input logic [3:0] base_reg, input logic [31:0] base,
                                          input logic pre, input logic up, input logic wb,
                                          input logic [31:0] iaddr);
        t_instr ins;
        ins = '{func, mask, base_reg, base, pre, up, wb, iaddr};
        return ins;
    endfunction

    // Mostly short masks to keep the run brisk; a few empty and full ones.
    function automatic t_instr random_instruction();
        t_instr      ins;
        int unsigned pick;
        int unsigned bit_pos;
        ins.func     = $urandom_range(0, 1) ? FuncLoad : FuncStore;
        ins.base_reg = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            ins.mask = '0;
        end else if (pick < 16) begin
            ins.mask = 16'hFFFF;
        end else if (pick < 70) begin
            ins.mask = '0;
            repeat ($urandom_range(1, 4)) begin
                bit_pos = $urandom_range(0, 15);
                ins.mask[bit_pos] = 1'b1;
            end
        end else begin
            ins.mask = 16'($urandom);
        end
        // Put the base in the list now and then so load writeback suppression is hit.
        if ($urandom_range(0, 3) == 0) begin
            ins.mask[ins.base_reg] = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            ins.base = 32'hFFFF_FFFF - $urandom_range(0, 80);
        end else if (pick < 4) begin
            ins.base = $urandom_range(0, 80);
        end else begin
            ins.base = $urandom;
        end
        ins.pre   = 1'($urandom_range(0, 1));
        ins.up    = 1'($urandom_range(0, 1));
        ins.wb    = 1'($urandom_range(0, 1));
        ins.iaddr = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 15)
                                                : $urandom;
        return ins;
    endfunction

    // Hold the payload until the block takes it.
    task automatic offer(input t_instr ins);
        i_valid               <= 1'b1;
        i_func                <= ins.func;
        i_register_mask       <= ins.mask;
        i_base_register       <= ins.base_reg;
        i_base_value          <= ins.base;
        i_pre_index           <= ins.pre;
        i_up                  <= ins.up;
        i_write_back          <= ins.wb;
        i_instruction_address <= ins.iaddr;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: stall on its own schedule; two segments hold off for a long stretch
    // so the block fills up and pushes back on its input.
    initial begin
        int unsigned seg;
        int unsigned len;
        int unsigned mode;
        int unsigned pct;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        seg = 0;
        forever begin
            if (seg == 3 || seg == 14) begin
                for (int c = 0; c < LongHold; c++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 60);
                pct  = (mode == 1) ? 50 : 75;
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        0: begin
                            i_stall <= 1'b0;
                        end
                        1, 2: begin
                            i_stall <= ($urandom_range(0, 99) < pct);
                        end
                        default: begin
                            i_stall <= (c % 3 == 0);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    // Hard stop for a hung block.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        int unsigned waited;
        i_rst_n               <= 1'b0;
        i_valid               <= 1'b0;
        i_func                <= FuncStore;
        i_register_mask       <= '0;
        i_base_register       <= '0;
        i_base_value          <= '0;
        i_pre_index           <= 1'b0;
        i_up                  <= 1'b0;
        i_write_back          <= 1'b0;
        i_instruction_address <= '0;

        // Directed: empty masks, full masks in every addressing mode, wraps, base in list.
        stimulus = {stimulus, make_instr(FuncStore, 16'h0000, 4'd2, 32'h0000_1000,
                                         1'b0, 1'b1, 1'b1, 32'h0000_0100)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'h0000, 4'd2, 32'h0000_1000,
                                         1'b1, 1'b0, 1'b0, 32'h0000_0200)};
        stimulus = {stimulus, make_instr(FuncStore, 16'hFFFF, 4'd3, 32'h4000_0000,
                                         1'b1, 1'b1, 1'b1, 32'h0000_8000)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'hFFFF, 4'd3, 32'h4000_0000,
                                         1'b0, 1'b1, 1'b1, 32'h0000_8004)};
        stimulus = {stimulus, make_instr(FuncStore, 16'hFFFF, 4'd3, 32'h4000_0000,
                                         1'b1, 1'b0, 1'b1, 32'h0000_8008)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'hFFFF, 4'd3, 32'h4000_0000,
                                         1'b0, 1'b0, 1'b1, 32'h0000_800C)};
        // Program counter store with the +12 wrapping past the top.
        stimulus = {stimulus, make_instr(FuncStore, 16'h8000, 4'd13, 32'h2000_0000,
                                         1'b1, 1'b0, 1'b1, 32'hFFFF_FFF8)};
        // Descending from address zero wraps low.
        stimulus = {stimulus, make_instr(FuncLoad, 16'h0001, 4'd13, 32'h0000_0000,
                                         1'b1, 1'b0, 1'b1, 32'h0000_0010)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'h0030, 4'd4, 32'h0000_2000,
                                         1'b0, 1'b1, 1'b1, 32'h0000_0020)};
        stimulus = {stimulus, make_instr(FuncStore, 16'h0030, 4'd4, 32'h0000_2000,
                                         1'b0, 1'b1, 1'b1, 32'h0000_0024)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'h0030, 4'd6, 32'h0000_2000,
                                         1'b1, 1'b1, 1'b1, 32'h0000_0028)};
        stimulus = {stimulus, make_instr(FuncStore, 16'hFFFF, 4'd0, 32'hFFFF_FFFC,
                                         1'b1, 1'b1, 1'b1, 32'h0000_0030)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'hFFFF, 4'd15, 32'hFFFF_FFFF,
                                         1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF)};
        stimulus = {stimulus, make_instr(FuncStore, 16'h0000, 4'd0, 32'h0000_0000,
                                         1'b0, 1'b0, 1'b0, 32'h0000_0000)};
        stimulus = {stimulus, make_instr(FuncLoad, 16'h8000, 4'd15, 32'h0000_3000,
                                         1'b0, 1'b1, 1'b1, 32'h0000_0040)};
        stimulus = {stimulus, make_instr(FuncStore, 16'h8001, 4'd1, 32'h0000_3000,
                                         1'b0, 1'b0, 1'b0, 32'h0000_0044)};
        for (int i = 0; i < RandomItems; i++) begin
            stimulus = {stimulus, random_instruction()};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender: bursts of random length, random gaps between them, sometimes none.
        idx = 0;
        while (idx < stimulus.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < stimulus.size()) begin
                offer(stimulus[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        // Let the monitor note the last accepted instruction before draining.
        @(posedge i_clk);

        // Drain, then give stray results a chance to show up.
        waited = 0;
        while (sb.expected_transfers.size() != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleTime) @(posedge i_clk);
        if (sb.expected_transfers.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected transfers never arrived",
                                         sb.expected_transfers.size()));
        end
        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
